/* rtl/api_frame_deframer_checksum_assert.svh */
// Assertion macros shared by the deframer checker.
`ifndef API_FRAME_DEFRAMER_CHECKSUM_ASSERT_SVH
`define API_FRAME_DEFRAMER_CHECKSUM_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AFD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

// Next-cycle implication, checked outside reset.
`define AFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`endif

/* rtl/afd_pkg.sv */
// Package: result kinds, framing constants and controller/datapath interface types.
package afd_pkg;

	localparam logic [7:0] DELIM     = 8'h7E;
	localparam logic [7:0] ESC       = 8'h7D;
	localparam logic [7:0] ESC_XOR   = 8'h20;
	localparam logic [7:0] SUM_OK    = 8'hFF;
	localparam int         STORE_MAX = 60;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_CKSUM   = 2'd1,
		KIND_PARTIAL = 2'd2,
		KIND_LONG    = 2'd3
	} kind_t;

	typedef struct packed {
		logic  cap_in;     // capture the accepted input beat
		logic  unesc;      // apply the escape XOR to the held byte
		logic  frame_clr;  // clear sum and length for a new frame
		logic  len_hi;     // take the length high byte
		logic  len_lo;     // take the length low byte
		logic  store;      // write payload byte, add to sum, advance index
		logic  idx_clr;    // rewind the byte index
		logic  idx_inc;    // advance the byte index
		logic  mem_rd;     // read the payload store at the byte index
		logic  out_load;   // load the output register
		kind_t out_kind;
	} dp_cmd_t;

	typedef struct packed {
		logic is_delim;
		logic is_esc;
		logic too_long;
		logic idx_lt_len;
		logic sum_ok;
		logic len_zero;
		logic emit_last;
		logic out_free;
	} dp_sts_t;

endpackage

/* rtl/afd_dp.sv */
// Datapath: input holding register, length, checksum, payload store and output register.
module afd_dp
	import afd_pkg::*;
#(
	parameter int CAPACITY = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [5:0]  byte_index,
	output logic        last
);

	localparam int         IW   = $clog2(CAPACITY + 1);
	localparam int         AW   = $clog2(CAPACITY);
	localparam logic [7:0] CAP8 = 8'(CAPACITY);

	logic [7:0]    in_byte_q;
	logic [7:0]    ub;
	logic          hi_nz_q;
	logic [IW-1:0] len_q;
	logic [IW-1:0] idx_q;
	logic [7:0]    sum_q;
	logic [7:0]    store_q [CAPACITY];
	logic [7:0]    rd_data_q;
	logic          out_valid_q;
	kind_t         kind_q;
	logic [7:0]    data_q;
	logic [5:0]    index_q;
	logic          last_q;

	assign ub = cmd.unesc ? (in_byte_q ^ ESC_XOR) : in_byte_q;

	always_comb begin
		sts.is_delim   = (in_byte_q == DELIM);
		sts.is_esc     = (in_byte_q == ESC);
		sts.too_long   = hi_nz_q || (ub > CAP8);
		sts.idx_lt_len = (idx_q < len_q);
		sts.sum_ok     = (8'(sum_q + ub) == SUM_OK);
		sts.len_zero   = (len_q == '0);
		sts.emit_last  = (({1'b0, idx_q} + 1'b1) == {1'b0, len_q});
		sts.out_free   = !out_valid_q || !out_stall;
	end

	// Frame bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			in_byte_q <= rx_byte;
		end
		if (cmd.frame_clr) begin
			sum_q   <= '0;
			hi_nz_q <= 1'b0;
			len_q   <= '0;
		end
		if (cmd.len_hi) begin
			hi_nz_q <= (ub != 8'h00);
		end
		if (cmd.len_lo) begin
			len_q <= ub[IW-1:0];
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.store || cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.store) begin
			sum_q <= 8'(sum_q + ub);
		end
	end

	// Payload store
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			store_q[idx_q[AW-1:0]] <= ub;
		end
		if (cmd.mem_rd) begin
			rd_data_q <= store_q[idx_q[AW-1:0]];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q <= cmd.out_kind;
			if (cmd.out_kind == KIND_DATA) begin
				data_q  <= rd_data_q;
				index_q <= 6'(idx_q);
				last_q  <= sts.emit_last;
			end else begin
				data_q  <= '0;
				index_q <= '0;
				last_q  <= 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign data_byte  = data_q;
	assign byte_index = index_q;
	assign last       = last_q;

endmodule

/* rtl/afd_ctrl.sv */
// Controller: frame parsing state machine and payload emission sequencer.
module afd_ctrl
	import afd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_PAYLOAD,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	state_t state_q, state_n;
	logic   esc_q, esc_n;
	logic   in_full_q;
	logic   proc;

	assign in_stall = in_full_q;

	always_comb begin
		cmd          = '0;
		cmd.out_kind = KIND_DATA;
		cmd.cap_in   = in_valid && !in_full_q;
		cmd.unesc    = esc_q;
		state_n      = state_q;
		esc_n        = esc_q;
		proc         = 1'b0;
		case (state_q)
			ST_EMIT_RD: begin
				cmd.mem_rd = 1'b1;
				state_n    = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_DATA;
					if (sts.emit_last) begin
						state_n = ST_HUNT;
					end else begin
						cmd.idx_inc = 1'b1;
						state_n     = ST_EMIT_RD;
					end
				end
			end
			default: begin
				proc = in_full_q && sts.out_free;
				if (proc) begin
					if (sts.is_delim) begin
						if (state_q != ST_HUNT) begin
							cmd.out_load = 1'b1;
							cmd.out_kind = KIND_PARTIAL;
						end
						cmd.frame_clr = 1'b1;
						esc_n         = 1'b0;
						state_n       = ST_LEN_HI;
					end else if (state_q == ST_HUNT) begin
						state_n = ST_HUNT;
					end else if (sts.is_esc) begin
						esc_n = 1'b1;
					end else begin
						esc_n = 1'b0;
						if (state_q == ST_LEN_HI) begin
							cmd.len_hi = 1'b1;
							state_n    = ST_LEN_LO;
						end else if (state_q == ST_LEN_LO) begin
							if (sts.too_long) begin
								cmd.out_load = 1'b1;
								cmd.out_kind = KIND_LONG;
								state_n      = ST_HUNT;
							end else begin
								cmd.len_lo  = 1'b1;
								cmd.idx_clr = 1'b1;
								state_n     = ST_PAYLOAD;
							end
						end else if (sts.idx_lt_len) begin
							cmd.store = 1'b1;
						end else if (!sts.sum_ok) begin
							cmd.out_load = 1'b1;
							cmd.out_kind = KIND_CKSUM;
							state_n      = ST_HUNT;
						end else if (sts.len_zero) begin
							state_n = ST_HUNT;
						end else begin
							cmd.idx_clr = 1'b1;
							state_n     = ST_EMIT_RD;
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_HUNT;
			esc_q     <= 1'b0;
			in_full_q <= 1'b0;
		end else begin
			state_q <= state_n;
			esc_q   <= esc_n;
			if (cmd.cap_in) begin
				in_full_q <= 1'b1;
			end else if (proc) begin
				in_full_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/api_frame_deframer_checksum.sv */
// Top level of the escaped API-frame deframer with checksum check.
//
// Input channel: one raw serial byte per beat on rx_byte (in_valid/in_stall).
// Output channel: one result per beat (out_valid/out_stall) carrying kind,
// data_byte, byte_index and last. Kind 0 is a payload byte; kinds 1, 2 and 3
// report a checksum error, a discarded partial frame and an over-long length,
// each as a single beat with last set and zero data and index.
// A byte is taken into a holding register and parsed from there; no new
// input beat is accepted until the held byte has been parsed.
// Frame bytes are stored as they arrive. When the checksum byte passes, the
// stored payload is walked through the single-port store: each payload byte
// is read, then loaded into the output register; input beats wait in the
// holding register meanwhile.
// Payload capacity is min(BUF_DEPTH - 4, 60) bytes; longer frames are dropped.
// When the receiver stalls, the output beat holds and the parser waits for the
// output register before consuming its next byte.
// Reset returns the parser to delimiter hunting and drops any pending beat;
// the payload store is not cleared, since only bytes of the current frame are read.
module api_frame_deframer_checksum
	import afd_pkg::*;
#(
	parameter int BUF_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [5:0] byte_index,
	output logic       last
);

	// Payload bytes that fit; the rest of the buffer is header and checksum.
	localparam int CAPACITY = ((BUF_DEPTH - 4) < STORE_MAX) ? (BUF_DEPTH - 4) : STORE_MAX;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Parse bytes and sequence the emission of a good frame.
	afd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the byte, track length and checksum, store and replay the payload.
	afd_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.byte_index (byte_index),
		.last       (last)
	);

endmodule

/* rtl/afd_checker.sv */
// Port-level checker for the deframer, bound to the top level.
`include "api_frame_deframer_checksum_assert.svh"

module afd_checker
	import afd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] kind,
	input logic [7:0] data_byte,
	input logic [5:0] byte_index,
	input logic       last
);

	// Status beats carry last and no data.
	`AFD_ASSERT_SAME(a_status_shape, out_valid && (kind != KIND_DATA),
		last && (data_byte == 8'h00) && (byte_index == 6'd0))
	// Payload index stays below STORE_MAX, the largest store size.
	`AFD_ASSERT_SAME(a_index_range, out_valid && (kind == KIND_DATA),
		byte_index < 6'(STORE_MAX))
	// A taken input beat fills the holding register.
	`AFD_ASSERT_NEXT(a_in_hold, in_valid && !in_stall, in_stall)
	// A stalled result beat holds.
	`AFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(kind) && $stable(data_byte) && $stable(byte_index) && $stable(last))

endmodule

bind api_frame_deframer_checksum afd_checker u_chk (.*);
